### src/quadratic_root_solver_core_assert.svh
// Assertion macros for the quadratic root solver core.
// Used by qrs_queue and the top level; depends on nothing else.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, held off while reset is high.
`define QRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define QRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRS_ASSERT(lbl, clk, rst, prop, msg)
`define QRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/qrs_pkg.sv
// Shared types and constants of the quadratic root solver core.
// Used by every module of the block; depends on nothing.
package qrs_pkg;

  typedef enum logic [2:0] {
    KIND_TWO_REAL = 3'd0,
    KIND_DOUBLE   = 3'd1,
    KIND_COMPLEX  = 3'd2,
    KIND_LINEAR   = 3'd3,
    KIND_ANY      = 3'd4,
    KIND_NONE     = 3'd5
  } kind_t;

  typedef struct packed {
    logic signed [15:0] coef_quad;
    logic signed [15:0] coef_lin;
    logic signed [15:0] coef_const;
  } coef_t;

  typedef struct packed {
    kind_t              root_kind;
    logic signed [35:0] discriminant;
    logic signed [31:0] root_first;
    logic signed [31:0] root_second;
    logic               saturated;
  } result_t;

  localparam int MAG_W      = 34;              // |b*b - 4ac|
  localparam int RAD_W      = MAG_W + 16;      // |D| * 2^16
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  localparam int NUM_W      = 36;              // signed divider numerator
  localparam int DEN_W      = 17;              // signed divider denominator
  localparam int NMAG_W     = NUM_W - 1;
  localparam int DMAG_W     = DEN_W - 1;
  localparam int DIV_STEPS  = NMAG_W;
  localparam int DIV_LAT    = DIV_STEPS + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int FRONT_LAT = 2;
  localparam int PIPE_LAT  = FRONT_LAT + 1 + SQRT_LAT + DIV_LAT + 1;

  typedef struct packed {
    kind_t              kind;
    logic signed [35:0] disc;
    logic [MAG_W-1:0]   mag;
    coef_t              coef;
  } front_item_t;

endpackage

### src/qrs_front.sv
// Front part: products, discriminant and classification of one item.
// Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  coef_t       coef,
  output logic        out_valid,
  output front_item_t out_item
);

  logic               v1;
  coef_t              coef1;
  logic signed [31:0] lin_sq;
  logic signed [31:0] quad_const;
  logic signed [35:0] disc_next;
  kind_t              kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    coef1      <= coef;
    lin_sq     <= 32'(coef.coef_lin) * 32'(coef.coef_lin);
    quad_const <= 32'(coef.coef_quad) * 32'(coef.coef_const);
    out_item.kind <= kind_next;
    out_item.disc <= disc_next;
    out_item.mag  <= (disc_next < 0) ? MAG_W'(-disc_next) : MAG_W'(disc_next);
    out_item.coef <= coef1;
  end

  always_comb begin
    disc_next = 36'(lin_sq) - (36'(quad_const) <<< 2);
    if (coef1.coef_quad != 16'sd0) begin
      if (disc_next > 0)       kind_next = KIND_TWO_REAL;
      else if (disc_next == 0) kind_next = KIND_DOUBLE;
      else                     kind_next = KIND_COMPLEX;
    end else begin
      disc_next = '0;
      if (coef1.coef_lin != 16'sd0)        kind_next = KIND_LINEAR;
      else if (coef1.coef_const == 16'sd0) kind_next = KIND_ANY;
      else                                 kind_next = KIND_NONE;
    end
  end

endmodule

### src/qrs_queue.sv
// Short queue between the front and back parts; drains one item a cycle.
// Depends on qrs_pkg and the assertion macro header.
`include "quadratic_root_solver_core_assert.svh"
module qrs_queue import qrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t push_item,
  output logic        full,
  output logic        pop_valid,
  output front_item_t pop_item
);

  front_item_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid;
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) entries[wr_ptr] <= push_item;
  end

  `QRS_ASSERT(a_no_overflow, clk, rst, push |-> !full, "push into full queue")
  `QRS_ASSERT(a_count_range, clk, rst, count <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
  `QRS_ASSERT(a_drain, clk, rst, (pop && !push) |=> (count == $past(count) - 1'b1), "queue did not drain")

endmodule

### src/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk,
  input  logic [MAG_W-1:0]  mag,
  output logic [ROOT_W-1:0] root
);

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_stage_t;

  sq_stage_t stages [SQRT_STEPS + 1];

  function automatic sq_stage_t sq_step(sq_stage_t s);
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] trial;
    sq_stage_t         n;
    t     = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (t >= trial) begin
      n.rem  = SREM_W'(t - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = t[SREM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    stages[0].rem  <= '0;
    stages[0].root <= '0;
    stages[0].rad  <= {mag, 16'h0000};
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      stages[k] <= sq_step(stages[k-1]);
    end
  end

  assign root = stages[SQRT_STEPS].root;

endmodule

### src/qrs_div.sv
// Pipelined signed divider, truncating, saturated to Q16.16.
// Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; (
  input  logic                    clk,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic signed [31:0]      quot,
  output logic                    sat
);

  typedef struct packed {
    logic [DMAG_W-1:0] rem;
    logic [NMAG_W-1:0] nq;
    logic [DMAG_W-1:0] d;
    logic              neg;
  } dv_stage_t;

  localparam logic [NMAG_W-1:0] POS_LIM = NMAG_W'(32'h7FFF_FFFF);
  localparam logic [NMAG_W-1:0] NEG_LIM = NMAG_W'(33'h0_8000_0000);

  dv_stage_t stages [DIV_STEPS + 1];
  dv_stage_t last;

  function automatic dv_stage_t dv_step(dv_stage_t s);
    logic [DMAG_W:0] t;
    dv_stage_t       n;
    n   = s;
    t   = {s.rem, s.nq[NMAG_W-1]};
    if (t >= {1'b0, s.d}) begin
      n.rem = DMAG_W'(t - {1'b0, s.d});
      n.nq  = {s.nq[NMAG_W-2:0], 1'b1};
    end else begin
      n.rem = t[DMAG_W-1:0];
      n.nq  = {s.nq[NMAG_W-2:0], 1'b0};
    end
    return n;
  endfunction

  assign last = stages[DIV_STEPS];

  always_ff @(posedge clk) begin
    stages[0].rem <= '0;
    stages[0].nq  <= (num < 0) ? NMAG_W'(-num) : NMAG_W'(num);
    stages[0].d   <= (den < 0) ? DMAG_W'(-den) : DMAG_W'(den);
    stages[0].neg <= (num < 0) ^ (den < 0);
    for (int k = 1; k <= DIV_STEPS; k++) begin
      stages[k] <= dv_step(stages[k-1]);
    end
    if (last.neg) begin
      sat  <= last.nq > NEG_LIM;
      quot <= (last.nq > NEG_LIM) ? 32'sh8000_0000 : 32'(-$signed({1'b0, last.nq}));
    end else begin
      sat  <= last.nq > POS_LIM;
      quot <= (last.nq > POS_LIM) ? 32'sh7FFF_FFFF : 32'(last.nq);
    end
  end

endmodule

### src/qrs_back.sv
// Back part: square root, numerators, two dividers and the result register.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
module qrs_back import qrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  front_item_t in_item,
  output logic        done,
  output result_t     result
);

  typedef struct packed {
    kind_t              kind;
    logic signed [35:0] disc;
  } side_t;

  logic [SQRT_LAT-1:0] va;
  front_item_t         pa [SQRT_LAT];
  logic [DIV_LAT-1:0]  vb;
  side_t               pb [DIV_LAT];

  logic [ROOT_W-1:0]       root;
  front_item_t             sa;
  logic signed [NUM_W-1:0] nb, s36, n1, n2;
  logic signed [DEN_W-1:0] d1, d2, da;
  logic signed [31:0]      q1, q2;
  logic                    sat1, sat2;

  qrs_sqrt u_sqrt (.clk(clk), .mag(in_item.mag), .root(root));

  qrs_div u_div_first  (.clk(clk), .num(n1), .den(d1), .quot(q1), .sat(sat1));
  qrs_div u_div_second (.clk(clk), .num(n2), .den(d2), .quot(q2), .sat(sat2));

  assign sa = pa[SQRT_LAT-1];

  // Form both numerators and denominators as the root leaves its pipeline.
  always_comb begin
    nb  = -(NUM_W'(sa.coef.coef_lin) <<< 8);
    s36 = $signed(NUM_W'(root));
    da  = DEN_W'(sa.coef.coef_quad);
    n1  = '0;
    n2  = '0;
    d1  = DEN_W'(1);
    d2  = DEN_W'(1);
    case (sa.kind)
      KIND_TWO_REAL: begin
        n1 = (nb + s36) <<< 7;
        n2 = (nb - s36) <<< 7;
        d1 = da;
        d2 = da;
      end
      KIND_DOUBLE: begin
        n1 = nb <<< 7;
        n2 = nb <<< 7;
        d1 = da;
        d2 = da;
      end
      KIND_COMPLEX: begin
        n1 = nb <<< 7;
        n2 = s36 <<< 7;
        d1 = da;
        d2 = (da < 0) ? -da : da;
      end
      KIND_LINEAR: begin
        n1 = -(NUM_W'(sa.coef.coef_const) <<< 16);
        d1 = DEN_W'(sa.coef.coef_lin);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= '0;
      vb   <= '0;
      done <= 1'b0;
    end else begin
      va   <= {va[SQRT_LAT-2:0], in_valid};
      vb   <= {vb[DIV_LAT-2:0], va[SQRT_LAT-1]};
      done <= vb[DIV_LAT-1];
    end
    pa[0]      <= in_item;
    pb[0].kind <= sa.kind;
    pb[0].disc <= sa.disc;
    for (int k = 1; k < SQRT_LAT; k++) pa[k] <= pa[k-1];
    for (int k = 1; k < DIV_LAT; k++)  pb[k] <= pb[k-1];
    result.root_kind    <= pb[DIV_LAT-1].kind;
    result.discriminant <= pb[DIV_LAT-1].disc;
    result.root_first   <= q1;
    result.root_second  <= q2;
    result.saturated    <= sat1 | sat2;
  end

endmodule

### src/quadratic_root_solver_core.sv
// Top level of the quadratic root solver: front part, queue, back part.
// Depends on qrs_pkg, qrs_front, qrs_queue, qrs_back and the assertion header.
//
//  channel   signals               direction  accepted when
//  -------   --------------------  ---------  ------------------------------
//  coef      start, busy, coef     in         rising edge, start & !busy
//  result    done, result          out        rising edge ending the done cycle
//
// One item enters per cycle while busy is low; each item's result leaves after
// passing the front registers, the queue, the 25-stage square root pipeline and
// the 35-step restoring divider pipelines in the back part.
// Reset (rst, synchronous) empties the pipeline and the queue; no clearing pass.
// busy rises only when the queue is full; the back part drains one item each
// cycle and the receiver cannot stall, so busy stays low in operation.
`include "quadratic_root_solver_core_assert.svh"
module quadratic_root_solver_core import qrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  coef_t   coef,
  output logic    done,
  output result_t result
);

  logic        accept;
  logic        front_valid;
  front_item_t front_item;
  logic        back_valid;
  front_item_t back_item;

  // Take an item only while the queue has room.
  assign accept = start && !busy;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .coef      (coef),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  // Decouple classification from the long arithmetic pipeline.
  qrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_item (front_item),
    .full      (busy),
    .pop_valid (back_valid),
    .pop_item  (back_item)
  );

  // Run the root and divisions; drive the one-cycle result strobe.
  qrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (back_valid),
    .in_item  (back_item),
    .done     (done),
    .result   (result)
  );

  `QRS_ASSERT(a_latency, clk, rst, done |-> $past(accept, PIPE_LAT), "result without matching item")
  `QRS_ASSERT(a_trivial_zero, clk, rst, (done && (result.root_kind == KIND_ANY || result.root_kind == KIND_NONE)) |-> (result.root_first == 0 && result.root_second == 0 && !result.saturated), "nonzero roots on trivial kind")
  `QRS_ASSERT(a_linear_second, clk, rst, (done && result.root_kind == KIND_LINEAR) |-> (result.root_second == 0 && result.discriminant == 0), "linear result has second root or discriminant")

endmodule

### dv/quadratic_root_solver_core_tb.sv
// Self-checking testbench for quadratic_root_solver_core: a table of
// directed coefficient sets, then random ones, checked against hand-typed results or a predictor.
// Depends on qrs_pkg and the RTL of the core.
module quadratic_root_solver_core_tb import qrs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam int NUM_RANDOM = 2000;
  localparam int DRAIN_CYCLES = PIPE_LAT + 20;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  coef_t   coef = '0;
  logic    done;
  result_t result;

  quadratic_root_solver_core u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .coef   (coef),
    .done   (done),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One row of the directed table. Rows with has_exp carry a hand-typed result;
  // the rest are checked against the predictor.
  typedef struct {
    coef_t   c;
    bit      has_exp;
    result_t r;
  } row_t;

  result_t roots_due[$];   // expected results, oldest first
  coef_t   coefs_due[$];   // coefficients behind each expected result
  bit      failed = 1'b0;

  // Integer square root, floor, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Truncating division, clamped to the Q16.16 range; flags the clamp.
  function automatic logic [31:0] clamp_div(longint num, longint den, inout bit sat);
    longint q;
    q = num / den;
    if (q > Q_HI) begin
      q = Q_HI;
      sat = 1'b1;
    end else if (q < Q_LO) begin
      q = Q_LO;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  function automatic result_t solve_roots(coef_t cf);
    result_t r;
    longint a, b, c, nb, disc, s;
    longint unsigned mag;
    bit sat;
    a = cf.coef_quad;
    b = cf.coef_lin;
    c = cf.coef_const;
    sat = 1'b0;
    disc = 0;
    r = '0;
    if (a != 0) begin
      nb = -b * 256;
      disc = b * b - 4 * a * c;
      mag = (disc < 0) ? longint'(-disc) : longint'(disc);
      s = longint'(int_sqrt(mag << 16));
      if (disc > 0) begin
        r.root_kind = KIND_TWO_REAL;
        r.root_first = clamp_div((nb + s) * 128, a, sat);
        r.root_second = clamp_div((nb - s) * 128, a, sat);
      end else if (disc == 0) begin
        r.root_kind = KIND_DOUBLE;
        r.root_first = clamp_div(nb * 128, a, sat);
        r.root_second = r.root_first;
      end else begin
        r.root_kind = KIND_COMPLEX;
        r.root_first = clamp_div(nb * 128, a, sat);
        r.root_second = clamp_div(s * 128, (a < 0) ? -a : a, sat);
      end
    end else if (b != 0) begin
      r.root_kind = KIND_LINEAR;
      r.root_first = clamp_div(-c * 65536, b, sat);
    end else if (c == 0) begin
      r.root_kind = KIND_ANY;
    end else begin
      r.root_kind = KIND_NONE;
    end
    r.discriminant = disc[35:0];
    r.saturated = sat;
    return r;
  endfunction

  function automatic row_t mk(int a, int b, int c);
    row_t rw;
    rw.c.coef_quad = a[15:0];
    rw.c.coef_lin = b[15:0];
    rw.c.coef_const = c[15:0];
    rw.has_exp = 1'b0;
    rw.r = '0;
    return rw;
  endfunction

  function automatic row_t mk_exp(int a, int b, int c, kind_t k, longint d,
                                  longint r1, longint r2, bit sat);
    row_t rw;
    rw = mk(a, b, c);
    rw.has_exp = 1'b1;
    rw.r.root_kind = k;
    rw.r.discriminant = d[35:0];
    rw.r.root_first = r1[31:0];
    rw.r.root_second = r2[31:0];
    rw.r.saturated = sat;
    return rw;
  endfunction

  // Random coefficient set, weighted toward the special cases.
  function automatic coef_t rand_coef();
    coef_t cf;
    int sel;
    cf = coef_t'(48'({$urandom, $urandom}));
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1: cf.coef_quad = '0;                            // linear
      2: begin                                            // any / none
        cf.coef_quad = '0;
        cf.coef_lin = '0;
        if ($urandom_range(0, 1)) cf.coef_const = '0;
      end
      3, 4: cf.coef_lin = '0;
      5: cf.coef_const = '0;
      6, 7, 8: begin                                      // small values
        cf.coef_quad = 16'($signed($urandom_range(0, 1024)) - 512);
        cf.coef_lin = 16'($signed($urandom_range(0, 2048)) - 1024);
        cf.coef_const = 16'($signed($urandom_range(0, 1024)) - 512);
      end
      9: begin                                            // double root: b^2 = 4ac
        cf.coef_quad = 16'($urandom_range(1, 64));
        cf.coef_const = cf.coef_quad;
        cf.coef_lin = 16'(2 * cf.coef_quad);
        if ($urandom_range(0, 1)) cf.coef_lin = -cf.coef_lin;
      end
      default: ;
    endcase
    return cf;
  endfunction

  // Check each result as it leaves against the oldest one that send_item captured.
  // Sampled at the falling edge, clear of the rising-edge updates.
  always @(negedge clk) begin
    result_t exp_r;
    coef_t   exp_c;
    if (!rst && done) begin
      if (roots_due.size() == 0) begin
        $display("%0t: result with none due, actual %p", $time, result);
        failed = 1'b1;
      end else begin
        exp_r = roots_due.pop_front();
        exp_c = coefs_due.pop_front();
        if (result.root_kind !== exp_r.root_kind) begin
          $display("%0t: root_kind for %p expected %0d actual %0d", $time, exp_c,
                   exp_r.root_kind, result.root_kind);
          failed = 1'b1;
        end
        if (result.discriminant !== exp_r.discriminant) begin
          $display("%0t: discriminant for %p expected %0d actual %0d", $time, exp_c,
                   exp_r.discriminant, result.discriminant);
          failed = 1'b1;
        end
        if (result.root_first !== exp_r.root_first) begin
          $display("%0t: root_first for %p expected %0d actual %0d", $time, exp_c,
                   exp_r.root_first, result.root_first);
          failed = 1'b1;
        end
        if (result.root_second !== exp_r.root_second) begin
          $display("%0t: root_second for %p expected %0d actual %0d", $time, exp_c,
                   exp_r.root_second, result.root_second);
          failed = 1'b1;
        end
        if (result.saturated !== exp_r.saturated) begin
          $display("%0t: saturated for %p expected %0d actual %0d", $time, exp_c,
                   exp_r.saturated, result.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // Hold start and coef until the item is taken: busy is checked mid-cycle,
  // and when low the next rising edge takes the item.
  task automatic send_item(coef_t cf, bit has_exp, result_t r);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    coef <= cf;
    @(negedge clk);
    while (busy) @(negedge clk);
    roots_due.push_back(has_exp ? r : solve_roots(cf));
    coefs_due.push_back(cf);
    @(posedge clk);
  endtask

  row_t table_rows[$];

  initial begin
    // Hand-checked rows: trivial kinds, unit roots, clamps.
    table_rows.push_back(mk_exp(0, 0, 0, KIND_ANY, 0, 0, 0, 0));
    table_rows.push_back(mk_exp(0, 0, 1, KIND_NONE, 0, 0, 0, 0));
    table_rows.push_back(mk_exp(0, 0, -32768, KIND_NONE, 0, 0, 0, 0));
    table_rows.push_back(mk_exp(0, 256, -256, KIND_LINEAR, 0, 65536, 0, 0));
    table_rows.push_back(mk_exp(256, 0, -256, KIND_TWO_REAL, 262144, 65536, -65536, 0));
    table_rows.push_back(mk_exp(256, 512, 256, KIND_DOUBLE, 0, -65536, -65536, 0));
    table_rows.push_back(mk_exp(256, 0, 256, KIND_COMPLEX, -262144, 0, 65536, 0));
    table_rows.push_back(mk_exp(1, -32768, 0, KIND_TWO_REAL, 1073741824, Q_HI, 0, 1));
    table_rows.push_back(mk_exp(0, 1, -32768, KIND_LINEAR, 0, Q_HI, 0, 1));
    // Predicted rows: extremes, sign mixes, smallest positive discriminant.
    table_rows.push_back(mk(0, -1, -32768));
    table_rows.push_back(mk(0, -32768, 32767));
    table_rows.push_back(mk(1, 1, 0));
    table_rows.push_back(mk(-32768, -32768, -32768));
    table_rows.push_back(mk(32767, 32767, 32767));
    table_rows.push_back(mk(-32768, 32767, 32767));
    table_rows.push_back(mk(32767, -32768, -32768));
    table_rows.push_back(mk(-1, 0, -32768));
    table_rows.push_back(mk(1, 0, 32767));
    table_rows.push_back(mk(-1, -32768, 32767));
    table_rows.push_back(mk(-256, 512, -256));
    table_rows.push_back(mk(1, 32767, -32768));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) send_item(table_rows[i].c, table_rows[i].has_exp, table_rows[i].r);
    for (int n = 0; n < NUM_RANDOM; n++) send_item(rand_coef(), 1'b0, result_t'('0));
    start <= 1'b0;

    // Drain, then keep watching a while for stray results.
    while (roots_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit, far past the slowest correct run.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
